// ===== design/tcce_pkg.sv =====
// shared types and constants of the text console cursor engine
package tcce_pkg;

    localparam logic [6:0] CH_QMARK = 7'h3F;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_LF    = 7'h0A;

    localparam int unsigned REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_ENABLED      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 2'd2;

    localparam logic [1:0] CONT_PREFIX = 2'b10;

    localparam int unsigned TDATA_W = 64;

    typedef struct packed {
        logic       console_enabled;
        logic [7:0] column_count;
        logic [7:0] row_count;
    } cfg_t;

    typedef struct packed {
        logic [15:0] cursor_offset;
        logic [7:0]  cursor_row;
        logic [7:0]  cursor_column;
        logic        scroll_up;
        logic [6:0]  cell_char;
        logic [7:0]  cell_row;
        logic [7:0]  cell_column;
        logic        cell_write;
    } result_t;

endpackage

// ===== design/tcce_cfg_regs.sv =====
// configuration register bank of the text console cursor engine
module tcce_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcce_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output tcce_pkg::cfg_t                 cfg
);

    tcce_pkg::cfg_t cfg_reg;
    tcce_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                tcce_pkg::REG_ENABLED:      cfg_next.console_enabled = cfg_data[0];
                tcce_pkg::REG_COLUMN_COUNT: cfg_next.column_count    = cfg_data;
                tcce_pkg::REG_ROW_COUNT:    cfg_next.row_count       = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.console_enabled <= 1'b1;
            cfg_reg.column_count    <= 8'd80;
            cfg_reg.row_count       <= 8'd25;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/tcce_cursor.sv =====
// cursor state and per-byte cursor update logic
module tcce_cursor (
    input  logic                aclk,
    input  logic                aresetn,
    input  tcce_pkg::cfg_t      cfg,
    input  logic                step,
    input  logic [7:0]          byte_in,
    output logic                has_result,
    output tcce_pkg::result_t   result
);

    logic [7:0] cur_col_reg;
    logic [7:0] cur_row_reg;
    logic [7:0] cur_col_next;
    logic [7:0] cur_row_next;

    logic        size_ok;
    logic [6:0]  ch;
    logic [8:0]  col_inc;
    logic [8:0]  row_inc;
    logic [8:0]  col_calc;
    logic [8:0]  row_calc;
    logic        wrap_check;
    logic        scroll;
    logic [15:0] row_prod;

    always_comb begin
        size_ok    = cfg.console_enabled && (cfg.column_count != 8'd0)
                     && (cfg.row_count != 8'd0);
        has_result = size_ok && (byte_in[7:6] != tcce_pkg::CONT_PREFIX);
        ch         = byte_in[7] ? tcce_pkg::CH_QMARK : byte_in[6:0];
        col_inc    = {1'b0, cur_col_reg} + 9'd1;
        row_inc    = {1'b0, cur_row_reg} + 9'd1;

        result     = '0;
        col_calc   = col_inc;
        row_calc   = {1'b0, cur_row_reg};
        wrap_check = 1'b0;

        case (ch)
            tcce_pkg::CH_CR: begin
                col_calc = 9'd0;
            end
            tcce_pkg::CH_LF: begin
                col_calc   = 9'd0;
                row_calc   = row_inc;
                wrap_check = 1'b1;
            end
            default: begin
                result.cell_write  = 1'b1;
                result.cell_column = cur_col_reg;
                result.cell_row    = cur_row_reg;
                result.cell_char   = ch;
                if (col_inc >= {1'b0, cfg.column_count}) begin
                    col_calc   = 9'd0;
                    row_calc   = row_inc;
                    wrap_check = 1'b1;
                end
            end
        endcase

        scroll = wrap_check && (row_calc >= {1'b0, cfg.row_count});
        if (scroll) begin
            row_calc = {1'b0, cfg.row_count - 8'd1};
        end

        cur_col_next = col_calc[7:0];
        cur_row_next = row_calc[7:0];
        row_prod     = {8'd0, cur_row_next} * {8'd0, cfg.column_count};

        result.scroll_up     = scroll;
        result.cursor_column = cur_col_next;
        result.cursor_row    = cur_row_next;
        result.cursor_offset = row_prod + {8'd0, cur_col_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg <= 8'd0;
            cur_row_reg <= 8'd0;
        end else if (step && has_result) begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_col_reg != 8'hFF)
        else $error("cursor column reached an impossible value");

    a_scroll_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        has_result && result.scroll_up |-> result.cursor_row == cfg.row_count - 8'd1)
        else $error("scroll did not leave the cursor on the last row");

    a_no_write_home: assert property (@(posedge aclk) disable iff (!aresetn)
        has_result && !result.cell_write |-> result.cursor_column == 8'd0)
        else $error("carriage return or line feed left a nonzero column");

endmodule

// ===== design/text_console_cursor_engine_unit.sv =====
// Text console cursor engine: takes one UTF-8 byte per transfer and returns the
// cell write and cursor position it causes. One byte is accepted every cycle
// while the m_ side does not stall; a byte that gives a result passes the input
// register, then the result register, before it is offered on the m_ side.
// The cursor update loop, which reads and writes the column and row registers
// in the same cycle, sets that rate. Continuation bytes, and all bytes while the
// console is disabled or sized to zero, give no result. Configuration writes are
// taken every cycle.
module text_console_cursor_engine_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // byte_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cell_write, cell_column, cell_row, cell_char, scroll_up,
    // cursor_column, cursor_row, cursor_offset, zero fill
    output logic [tcce_pkg::TDATA_W-1:0]   m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcce_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    tcce_pkg::cfg_t    cfg;
    tcce_pkg::result_t res;
    logic              has_result;
    logic              consume;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    tcce_pkg::result_t out_data_reg;

    tcce_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcce_cursor u_cursor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .step       (consume),
        .byte_in    (in_byte_reg),
        .has_result (has_result),
        .result     (res)
    );

    assign consume  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tcce_pkg::TDATA_W - $bits(tcce_pkg::result_t)){1'b0}}, out_data_reg};

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (consume) begin
            out_valid_next = has_result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (consume && has_result) begin
            out_data_reg <= res;
        end
    end

    a_result_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a buffered input byte");

    a_stalled_input_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled while the pipeline could advance");

    a_stall_holds_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result changed");

endmodule
